@@ rtl/core/cle_pkg.sv @@
package cle_pkg;

    // Character codes handled by the editor.
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // Input opcodes.
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result kinds.
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Backspace echo sequence positions.
    localparam logic [1:0] STEP_FIRST = 2'd0;
    localparam logic [1:0] STEP_SPACE = 2'd1;
    localparam logic [1:0] STEP_FINAL = 2'd2;

    // One decoded item on its way to the output sequencer.
    typedef struct packed {
        logic [7:0] data;
        logic       is_read;
        logic       hit;
        logic       done;
        logic       bs;
        logic [7:0] len;
    } t_cmd;

endpackage

@@ rtl/core/cle_store.sv @@
module cle_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data is held until the next read, so a waiting read result stays put.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

@@ rtl/core/cle_edit.sv @@
module cle_edit #(
    parameter int LINE_DEPTH = 256,
    parameter int CW         = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_opcode,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_read_index,
    input  logic          i_cfg_we,
    input  logic [8:0]    i_cfg_wdata,
    output logic          o_emit,
    output cle_pkg::t_cmd o_cmd,
    output logic          o_wr_en,
    output logic [CW-1:0] o_wr_addr,
    output logic          o_rd_en,
    output logic [CW-1:0] o_rd_addr
);
    import cle_pkg::*;

    localparam int IW = (CW > 8) ? CW : 8;
    localparam int LW = (CW + 1 > 9) ? CW + 1 : 9;

    logic [CW-1:0] r_fill, n_fill;
    logic          r_closed, n_closed;
    logic [CW-1:0] r_cap, n_cap;
    logic [CW-1:0] base;
    logic [IW-1:0] idx_w, fill_w, nfill_w;
    logic [LW-1:0] wd;
    logic          printable;

    // The character limit is clamped once, when the register is written.
    always_comb begin
        wd = LW'(i_cfg_wdata);
        if (wd < LW'(2)) begin
            n_cap = CW'(1);
        end else if (wd > LW'(LINE_DEPTH)) begin
            n_cap = CW'(LINE_DEPTH - 1);
        end else begin
            n_cap = CW'(wd - LW'(1));
        end
    end

    always_comb begin
        base      = r_closed ? '0 : r_fill;
        idx_w     = IW'(i_read_index);
        fill_w    = IW'(r_fill);
        printable = (i_rx_byte >= CH_SPACE) && (i_rx_byte < CH_DEL);
        n_fill    = r_fill;
        n_closed  = r_closed;
        o_emit    = 1'b0;
        o_cmd     = '0;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = idx_w[CW-1:0];
        o_wr_addr = base;
        if (i_opcode == OP_READ) begin
            o_emit      = 1'b1;
            o_cmd.is_read = 1'b1;
            o_cmd.hit   = idx_w < fill_w;
            o_rd_en     = idx_w < fill_w;
        end else begin
            // A received byte after a closed line starts an empty one.
            n_fill   = base;
            n_closed = 1'b0;
            if (i_rx_byte == CH_CR || i_rx_byte == CH_LF) begin
                n_closed   = 1'b1;
                o_emit     = 1'b1;
                o_cmd.data = CH_LF;
                o_cmd.done = 1'b1;
            end else if (i_rx_byte == CH_BS || i_rx_byte == CH_DEL) begin
                if (base != '0) begin
                    n_fill   = base - CW'(1);
                    o_emit   = 1'b1;
                    o_cmd.bs = 1'b1;
                end
            end else if (printable) begin
                if (base < r_cap) begin
                    o_wr_en    = 1'b1;
                    n_fill     = base + CW'(1);
                    n_closed   = (base + CW'(1)) == r_cap;
                    o_emit     = 1'b1;
                    o_cmd.data = i_rx_byte;
                    o_cmd.done = (base + CW'(1)) == r_cap;
                end
            end
        end
        nfill_w   = IW'(n_fill);
        o_cmd.len = nfill_w[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_closed <= 1'b0;
            r_cap    <= CW'(((LINE_DEPTH < 256) ? LINE_DEPTH : 256) - 1);
        end else begin
            if (i_accept) begin
                r_fill   <= n_fill;
                r_closed <= n_closed;
            end
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
        end
    end

    // The limit never drops below one character.
    a_cap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap != '0)
        else $error("character limit is zero");

endmodule

@@ rtl/core/cle_out.sv @@
module cle_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  cle_pkg::t_cmd i_cmd,
    input  logic [7:0]    i_rd_data,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_kind,
    output logic          o_line_done,
    output logic [7:0]    o_line_length,
    output logic          o_last
);
    import cle_pkg::*;

    // Stage A holds the decoded item; stage B sends its one or three words.
    logic       r_a_valid;
    t_cmd       r_a;
    logic       r_b_valid;
    logic [7:0] r_b_data;
    logic       r_b_kind;
    logic       r_b_done;
    logic       r_b_bs;
    logic [7:0] r_b_len;
    logic [1:0] r_b_step;
    logic       b_free;
    logic       move;
    logic       b_last;
    logic [7:0] a_data;

    assign b_last  = !r_b_bs || (r_b_step == STEP_FINAL);
    assign b_free  = !r_b_valid || (i_out_ready && b_last);
    assign move    = r_a_valid && b_free;
    // Stage A can take a new item in the cycle its current one moves on.
    assign o_ready = !r_a_valid || b_free;

    // Read data is ready from the store in the cycle the item sits in stage A.
    always_comb begin
        if (r_a.is_read) begin
            a_data = r_a.hit ? i_rd_data : 8'd0;
        end else begin
            a_data = r_a.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_load) begin
            r_a_valid <= 1'b1;
        end else if (move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_step  <= STEP_FIRST;
        end else if (move) begin
            r_b_valid <= 1'b1;
            r_b_step  <= STEP_FIRST;
        end else if (r_b_valid && i_out_ready) begin
            if (b_last) begin
                r_b_valid <= 1'b0;
            end else begin
                r_b_step <= r_b_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_b_data <= a_data;
            r_b_kind <= r_a.is_read ? KIND_READ : KIND_ECHO;
            r_b_done <= r_a.done;
            r_b_bs   <= r_a.bs;
            r_b_len  <= r_a.len;
        end
    end

    always_comb begin
        if (r_b_bs) begin
            o_out_byte = (r_b_step == STEP_SPACE) ? CH_SPACE : CH_BS;
        end else begin
            o_out_byte = r_b_data;
        end
    end

    assign o_valid       = r_b_valid;
    assign o_byte_kind   = r_b_kind;
    assign o_line_done   = r_b_done;
    assign o_line_length = r_b_len;
    assign o_last        = b_last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_step == STEP_FIRST || r_b_step == STEP_SPACE
                       || r_b_step == STEP_FINAL) && (r_b_bs || r_b_step == STEP_FIRST))
        else $error("echo step out of range");

    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_kind == KIND_READ |-> !r_b_bs && !r_b_done)
        else $error("read result is not a single plain word");

    a_hold_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !b_free |=> r_a_valid && $stable(r_a))
        else $error("pending item lost while output busy");

    a_no_load_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_a_valid || b_free))
        else $error("item loaded over a pending item");

endmodule

@@ rtl/core/console_line_editor.sv @@
// Console line editor.
// Input channel (i_in_valid / o_in_ready) takes one word per item: an opcode,
// a received byte and a read index. A printable byte is stored in the line
// and echoed, backspace or DEL erases the last character and echoes three
// words, and CR or LF echoes LF and closes the line. A read item returns
// one stored byte, or zero at or past the current length.
// Output channel (o_out_valid / i_out_ready) delivers the result words in
// order; o_last marks the final word of each item.
// i_cfg_we / i_cfg_wdata write the line_limit register; the user must do so
// only while the block is idle (not enforced); it takes effect at once.
// An accepted item passes through stage A and the output register. Items
// with a single result word are accepted every cycle while the receiver
// keeps up; a backspace holds the output register for its three words. While
// the output register is busy or stalled, one item waits in a one-entry
// stage ahead of it, and then o_in_ready drops until that item moves on.
// Items that give no result are accepted whenever o_in_ready is high.
// Reset empties the line and sets the limit to its maximum. The line
// store itself is not cleared; only entries below the fill count are read.
module console_line_editor #(
    parameter int LINE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_kind,
    output logic       o_line_done,
    output logic [7:0] o_line_length,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata
);
    import cle_pkg::*;

    localparam int CW = $clog2(LINE_DEPTH);

    logic          accept;
    logic          emit;
    t_cmd          cmd;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign accept = i_in_valid && o_in_ready;

    cle_edit #(
        .LINE_DEPTH(LINE_DEPTH),
        .CW        (CW)
    ) u_edit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_rx_byte   (i_rx_byte),
        .i_read_index(i_read_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_emit      (emit),
        .o_cmd       (cmd),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    cle_store #(
        .DEPTH(LINE_DEPTH),
        .AW   (CW)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en && accept),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_rx_byte),
        .i_rd_en  (rd_en && accept),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    cle_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (emit && accept),
        .i_cmd        (cmd),
        .i_rd_data    (rd_data),
        .o_ready      (o_in_ready),
        .o_valid      (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_kind  (o_byte_kind),
        .o_line_done  (o_line_done),
        .o_line_length(o_line_length),
        .o_last       (o_last)
    );

endmodule

@@ sim/console_line_editor_tb.sv @@
module console_line_editor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cle_pkg::*;

    localparam int STORE_DEPTH  = 256;
    localparam int QUIET_CYCLES = 8;
    localparam int STUCK_LIMIT  = 3000;
    localparam int RANDOM_WORDS = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       kind;
        logic       done;
        logic [7:0] len;
        logic       last;
    } echo_word_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic       i_opcode;
    logic [7:0] i_rx_byte;
    logic [7:0] i_read_index;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_byte_kind;
    logic       o_line_done;
    logic [7:0] o_line_length;
    logic       o_last;
    logic       i_cfg_we;
    logic [8:0] i_cfg_wdata;

    // Predicted state of the editor.
    logic [7:0] line_chars [STORE_DEPTH];
    int         line_fill;
    bit         line_shut;
    logic [8:0] limit_reg;

    echo_word_t due_words[$];
    int         mismatches;
    int         stuck_cycles;
    bit         pacing;
    int         burst_left;
    logic [15:0] ready_pattern;
    int         ready_tick;

    console_line_editor dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_rx_byte    (i_rx_byte),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_kind  (o_byte_kind),
        .o_line_done  (o_line_done),
        .o_line_length(o_line_length),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void push_word(logic [7:0] data, logic kind, logic done, logic last);
        echo_word_t w;
        w.data = data;
        w.kind = kind;
        w.done = done;
        w.len  = line_fill[7:0];
        w.last = last;
        due_words.push_back(w);
    endfunction

    function automatic void edit_line(logic op, logic [7:0] ch, logic [7:0] idx);
        int lim;
        int cap;
        if (op == OP_READ) begin
            push_word((idx < line_fill) ? line_chars[idx] : 8'd0, KIND_READ, 1'b0, 1'b1);
            return;
        end
        // Any received byte after a closed line starts an empty one, even if ignored.
        if (line_shut) begin
            line_fill = 0;
            line_shut = 1'b0;
        end
        if (ch == CH_CR || ch == CH_LF) begin
            line_shut = 1'b1;
            push_word(CH_LF, KIND_ECHO, 1'b1, 1'b1);
        end else if (ch == CH_BS || ch == CH_DEL) begin
            if (line_fill != 0) begin
                line_fill--;
                push_word(CH_BS, KIND_ECHO, 1'b0, 1'b0);
                push_word(CH_SPACE, KIND_ECHO, 1'b0, 1'b0);
                push_word(CH_BS, KIND_ECHO, 1'b0, 1'b1);
            end
        end else if (ch >= CH_SPACE && ch < CH_DEL) begin
            lim = int'(limit_reg);
            if (lim < 2) lim = 2;
            if (lim > STORE_DEPTH) lim = STORE_DEPTH;
            cap = lim - 1;
            if (line_fill < cap) begin
                line_chars[line_fill] = ch;
                line_fill++;
                if (line_fill >= cap) line_shut = 1'b1;
                push_word(ch, KIND_ECHO, line_fill >= cap, 1'b1);
            end
        end
    endfunction

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
            mismatches++;
        end
    endfunction

    // Result checker and no-progress watchdog.
    always @(posedge i_clk) begin
        echo_word_t w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got byte %0d", $time,
                         o_out_byte);
                mismatches++;
            end else begin
                w = due_words.pop_front();
                check_field("out_byte", w.data, o_out_byte);
                check_field("byte_kind", w.kind, o_byte_kind);
                check_field("line_done", w.done, o_line_done);
                check_field("line_length", w.len, o_line_length);
                check_field("last", w.last, o_last);
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver stalls on a rotating pattern, reloaded at regular intervals;
    // now and then the pattern is all ones so that no stall occurs at all.
    always @(negedge i_clk) begin
        if (ready_tick % 64 == 0) begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
        end
        ready_tick++;
        i_out_ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    task automatic pace();
        int gap;
        if (!pacing) return;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_word(logic op, logic [7:0] ch, logic [7:0] idx);
        pace();
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_rx_byte    <= ch;
        i_read_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        edit_line(op, ch, idx);
    endtask

    task automatic send_char(logic [7:0] ch);
        send_word(OP_RX, ch, 8'($urandom));
    endtask

    task automatic send_read(logic [7:0] idx);
        send_word(OP_READ, 8'($urandom), idx);
    endtask

    // Lets every expected word arrive, then waits out QUIET_CYCLES for items
    // that produce nothing.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_line_limit(logic [8:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_reg = value;
    endtask

    task automatic test_echo_and_read();
        send_char(8'd65);
        send_char(CH_SPACE);
        send_char(8'd126);
        send_read(8'd0);
        send_read(8'd2);
        send_read(8'd3);
        send_read(8'd255);
        send_char(CH_CR);
        // Reads after the line closed still see the old line.
        send_read(8'd1);
    endtask

    task automatic test_erase_and_ignored();
        send_char(8'd120);
        send_char(8'd121);
        send_char(CH_BS);
        send_char(CH_DEL);
        send_char(CH_DEL);
        send_char(8'd0);
        send_char(8'd31);
        send_char(8'd128);
        send_char(8'd255);
        send_char(8'd9);
        send_char(8'd122);
        send_char(CH_LF);
        // An ignored byte still opens a new, empty line.
        send_char(8'd7);
        send_read(8'd0);
    endtask

    task automatic test_line_full();
        set_line_limit(9'd3);
        send_char(8'd97);
        send_char(8'd98);
        send_char(8'd99);
        set_line_limit(9'd0);
        send_char(8'd113);
        send_char(CH_BS);
        send_char(8'd114);
        set_line_limit(9'd1);
        send_char(8'd115);
        send_read(8'd0);
    endtask

    task automatic test_limit_lowered();
        set_line_limit(9'd256);
        send_char(CH_CR);
        repeat (5) send_char(8'($urandom_range(32, 126)));
        set_line_limit(9'd4);
        send_char(8'd100);
        send_char(CH_DEL);
        send_char(8'd101);
        send_read(8'd4);
        send_char(CH_CR);
    endtask

    task automatic test_long_line();
        pacing = 1'b1;
        set_line_limit(9'd300);
        send_char(CH_LF);
        repeat (255) send_char(8'($urandom_range(32, 126)));
        send_read(8'd0);
        send_read(8'd128);
        send_read(8'd200);
        send_read(8'd254);
        send_read(8'd255);
        set_line_limit(9'd511);
        send_char(8'd64);
        send_char(CH_CR);
    endtask

    task automatic test_random_lines();
        logic [8:0] limits [10] = '{9'd2, 9'd5, 9'd17, 9'd64, 9'd1, 9'd257, 9'd256,
                                    9'd9, 9'd511, 9'd33};
        int phase;
        int counted;
        int n;
        int r;
        logic [7:0] ch;
        phase = 0;
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            set_line_limit(limits[phase % 10]);
            phase++;
            repeat ($urandom_range(2, 5)) begin
                n = $urandom_range(1, 30);
                repeat (n) begin
                    r = $urandom_range(0, 99);
                    if (r < 10) begin
                        send_char(($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL);
                    end else if (r < 25) begin
                        if (r < 20 && line_fill > 0) send_read(8'($urandom_range(0, line_fill - 1)));
                        else send_read(8'($urandom));
                    end else if (r < 30) begin
                        do ch = 8'($urandom);
                        while ((ch >= CH_SPACE && ch < CH_DEL) || ch == CH_BS || ch == CH_CR ||
                               ch == CH_LF || ch == CH_DEL);
                        send_char(ch);
                        counted--;
                    end else begin
                        send_char(8'($urandom_range(32, 126)));
                    end
                    counted++;
                end
                if ($urandom_range(0, 4) != 0) begin
                    send_char(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
                    counted++;
                end
                if ($urandom_range(0, 19) == 0) drain_results();
            end
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_RX;
        i_rx_byte    = 8'd0;
        i_read_index = 8'd0;
        i_out_ready  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 9'd0;
        line_fill    = 0;
        line_shut    = 1'b0;
        limit_reg    = 9'd256;
        mismatches   = 0;
        stuck_cycles = 0;
        pacing       = 1'b0;
        burst_left   = 0;
        ready_tick   = 0;
        ready_pattern = 16'hFFFF;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_echo_and_read();
        test_erase_and_ignored();
        test_line_full();
        test_limit_lowered();
        test_long_line();
        test_random_lines();

        drain_results();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
